// ===== rtl/rect_dedup_filter_top_defines.svh =====
// Assertion macros for the rectangle de-duplication filter.
// Taken in by the top level; needs no other file.
`ifndef RECT_DEDUP_FILTER_TOP_DEFINES_SVH
`define RECT_DEDUP_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define RDF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define RDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rdf_pkg.sv =====
// Shared types and constants of the rectangle de-duplication filter.
// No dependencies; used by the controller, the datapath and the top level.
package rdf_pkg;

    localparam int MAX_KEPT   = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_BITS   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_BITS   = $clog2(MAX_KEPT + 1);
    localparam int SLOT_BITS  = 6;
    localparam int COUNT_BITS = 7;
    localparam int CFG_IDX_BITS = 2;
    localparam int MIN_SIDE   = 10;
    localparam int NEAR_SQ    = 100;

    typedef enum logic [2:0] {
        V_KEPT      = 3'd0,
        V_SMALL     = 3'd1,
        V_OFFSCREEN = 3'd2,
        V_DUP       = 3'd3,
        V_FULL      = 3'd4
    } t_verdict;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_VIEW_LEFT   = 2'd0,
        CFG_VIEW_TOP    = 2'd1,
        CFG_VIEW_RIGHT  = 2'd2,
        CFG_VIEW_BOTTOM = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                          start_set;
        logic signed [COORD_BITS-1:0]  edge_left;
        logic signed [COORD_BITS-1:0]  edge_top;
        logic signed [COORD_BITS-1:0]  edge_right;
        logic signed [COORD_BITS-1:0]  edge_bottom;
    } t_in_item;

    typedef struct packed {
        t_verdict               verdict;
        logic [SLOT_BITS-1:0]   slot;
        logic [COUNT_BITS-1:0]  kept_count;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] l;
        logic signed [COORD_BITS-1:0] t;
        logic signed [COORD_BITS-1:0] r;
        logic signed [COORD_BITS-1:0] b;
    } t_rect;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // take the input item
        logic issue;    // read the next kept rectangle
        logic commit;   // store if kept, load the output register
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic reject;     // too small or offscreen
        logic scan_end;   // every kept rectangle has been read
        logic pipe_busy;  // compare pipeline still holds entries
        logic out_free;   // output register can take a result
    } t_dp_status;

endpackage

// ===== rtl/rdf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module rdf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rdf_ctrl.sv =====
// Sequencer of the rectangle de-duplication filter.
// Depends on rdf_pkg for the command and status structs.
module rdf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rdf_pkg::t_dp_status i_status,
    output rdf_pkg::t_dp_cmd    o_cmd
);

    import rdf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.reject) begin
                    n_state = S_FINISH;
                end else if (i_status.scan_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.issue  = (r_state == S_SCAN) && !i_status.reject && !i_status.scan_end;
    assign o_cmd.commit = (r_state == S_FINISH) && i_status.out_free;

endmodule

// ===== rtl/rdf_dp.sv =====
// Datapath of the rectangle de-duplication filter: viewport registers, kept table,
// compare pipeline and output register. Depends on rdf_pkg and rdf_ram.
module rdf_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rdf_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [rdf_pkg::COORD_BITS-1:0]      i_cfg_data,
    input  rdf_pkg::t_in_item                   i_in_item,
    input  rdf_pkg::t_dp_cmd                    i_cmd,
    output rdf_pkg::t_dp_status                 o_status,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rdf_pkg::t_out_item                  o_out_item
);

    import rdf_pkg::*;

    localparam int C = COORD_BITS;

    // Center coordinate with the halving truncated toward zero.
    function automatic logic signed [C-1:0] f_center(input logic signed [C-1:0] a,
                                                     input logic signed [C-1:0] b);
        logic signed [C:0] s;
        logic signed [C:0] h;
        s = (C+1)'(a) + (C+1)'(b);
        h = (s + {{C{1'b0}}, s[C]}) >>> 1;
        return h[C-1:0];
    endfunction

    // Absolute difference of two centers; always fits C bits.
    function automatic logic [C-1:0] f_absdiff(input logic signed [C-1:0] a,
                                               input logic signed [C-1:0] b);
        logic signed [C:0] d;
        logic signed [C:0] m;
        d = (C+1)'(a) - (C+1)'(b);
        m = d[C] ? -d : d;
        return m[C-1:0];
    endfunction

    // Viewport registers.
    logic signed [C-1:0] r_view_l, r_view_t, r_view_r, r_view_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_l <= '0;
            r_view_t <= '0;
            r_view_r <= C'(1920);
            r_view_b <= C'(1080);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_VIEW_LEFT:   r_view_l <= i_cfg_data;
                CFG_VIEW_TOP:    r_view_t <= i_cfg_data;
                CFG_VIEW_RIGHT:  r_view_r <= i_cfg_data;
                CFG_VIEW_BOTTOM: r_view_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input checks, evaluated as the item is taken.
    logic signed [C:0] in_w, in_h;
    logic              in_small, in_offs;

    assign in_w = (C+1)'(i_in_item.edge_right) - (C+1)'(i_in_item.edge_left);
    assign in_h = (C+1)'(i_in_item.edge_bottom) - (C+1)'(i_in_item.edge_top);
    assign in_small = (in_w < (C+1)'(MIN_SIDE)) || (in_h < (C+1)'(MIN_SIDE));
    assign in_offs  = (i_in_item.edge_right < r_view_l) || (i_in_item.edge_bottom < r_view_t)
                   || (i_in_item.edge_left > r_view_r) || (i_in_item.edge_top > r_view_b);

    // Current item.
    t_rect               r_rect;
    logic signed [C-1:0] r_cx, r_cy;
    logic [C-1:0]        r_w, r_h;
    logic [2*C-1:0]      r_area;
    logic                r_small, r_offs;
    logic [CNT_BITS-1:0] r_total, r_rd_idx;
    logic                r_found;
    logic [IDX_BITS-1:0] r_hit_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rect.l <= i_in_item.edge_left;
            r_rect.t <= i_in_item.edge_top;
            r_rect.r <= i_in_item.edge_right;
            r_rect.b <= i_in_item.edge_bottom;
            r_cx     <= f_center(i_in_item.edge_left, i_in_item.edge_right);
            r_cy     <= f_center(i_in_item.edge_top, i_in_item.edge_bottom);
            r_w      <= in_w[C-1:0];
            r_h      <= in_h[C-1:0];
        end
        // Settles long before the first compare reaches the last stage.
        r_area <= r_w * r_h;
    end

    // Compare pipeline: RAM read, geometry, products, decision.
    t_rect               kept;
    logic [4*C-1:0]      ram_rdata;
    logic                r_v0, r_v1, r_v2;
    logic [IDX_BITS-1:0] r_idx0, r_idx1, r_idx2;
    logic [C-1:0]        r_adx, r_ady, r_iw, r_ih, r_kw, r_kh;
    logic                r_ovl1, r_ovl2;
    logic [2*C-1:0]      r_sqx, r_sqy, r_inter, r_karea;

    logic                 full, store;
    logic [IDX_BITS-1:0]  wr_idx;

    assign full   = (r_total == CNT_BITS'(MAX_KEPT));
    assign store  = i_cmd.commit && !r_small && !r_offs && !r_found && !full;
    assign wr_idx = r_total[IDX_BITS-1:0];

    rdf_ram #(
        .WIDTH (4 * C),
        .DEPTH (MAX_KEPT)
    ) u_kept_ram (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (wr_idx),
        .i_wdata (r_rect),
        .i_re    (i_cmd.issue),
        .i_raddr (r_rd_idx[IDX_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    assign kept = t_rect'(ram_rdata);

    logic signed [C-1:0] il, it, ir, ib;
    logic signed [C:0]   iw_full, ih_full, kw_full, kh_full;

    assign il = (r_rect.l > kept.l) ? r_rect.l : kept.l;
    assign it = (r_rect.t > kept.t) ? r_rect.t : kept.t;
    assign ir = (r_rect.r < kept.r) ? r_rect.r : kept.r;
    assign ib = (r_rect.b < kept.b) ? r_rect.b : kept.b;
    assign iw_full = (C+1)'(ir) - (C+1)'(il);
    assign ih_full = (C+1)'(ib) - (C+1)'(it);
    assign kw_full = (C+1)'(kept.r) - (C+1)'(kept.l);
    assign kh_full = (C+1)'(kept.b) - (C+1)'(kept.t);

    always_ff @(posedge i_clk) begin
        r_idx0  <= r_rd_idx[IDX_BITS-1:0];
        r_idx1  <= r_idx0;
        r_adx   <= f_absdiff(r_cx, f_center(kept.l, kept.r));
        r_ady   <= f_absdiff(r_cy, f_center(kept.t, kept.b));
        r_ovl1  <= (ir > il) && (ib > it);
        r_iw    <= iw_full[C-1:0];
        r_ih    <= ih_full[C-1:0];
        r_kw    <= kw_full[C-1:0];
        r_kh    <= kh_full[C-1:0];
        r_idx2  <= r_idx1;
        r_sqx   <= r_adx * r_adx;
        r_sqy   <= r_ady * r_ady;
        r_inter <= r_iw * r_ih;
        r_karea <= r_kw * r_kh;
        r_ovl2  <= r_ovl1;
    end

    logic [2*C:0]   dist_sq;
    logic [2*C-1:0] small_area;
    logic           near, over, hit;

    assign dist_sq    = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign near       = dist_sq < (2*C+1)'(NEAR_SQ);
    assign small_area = (r_area < r_karea) ? r_area : r_karea;
    assign over       = r_ovl2 && ({r_inter, 1'b0} > {1'b0, small_area});
    assign hit        = r_v2 && (near || over);

    // Control registers of the scan and the table fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0     <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_total  <= '0;
            r_rd_idx <= '0;
            r_found  <= 1'b0;
            r_small  <= 1'b0;
            r_offs   <= 1'b0;
        end else begin
            r_v0 <= i_cmd.issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            if (i_cmd.load) begin
                r_rd_idx <= '0;
                r_found  <= 1'b0;
                r_small  <= in_small;
                r_offs   <= in_offs;
                if (i_in_item.start_set) begin
                    r_total <= '0;
                end
            end else begin
                if (i_cmd.issue) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
                // Hits leave the pipeline in slot order, so the first one is kept.
                if (hit && !r_found) begin
                    r_found <= 1'b1;
                end
                if (store) begin
                    r_total <= r_total + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit && !r_found) begin
            r_hit_idx <= r_idx2;
        end
    end

    // Result selection and output register.
    logic [CNT_BITS-1:0]           count_next;
    logic [IDX_BITS-1:0]           slot_idx;
    logic [IDX_BITS+SLOT_BITS-1:0] slot_wide;
    logic [CNT_BITS+COUNT_BITS-1:0] count_wide;
    t_out_item                     result;
    t_out_item                     r_out;
    logic                          r_out_valid;

    always_comb begin
        count_next     = r_total;
        slot_idx       = '0;
        result.verdict = V_KEPT;
        if (r_small) begin
            result.verdict = V_SMALL;
        end else if (r_offs) begin
            result.verdict = V_OFFSCREEN;
        end else if (r_found) begin
            result.verdict = V_DUP;
            slot_idx       = r_hit_idx;
        end else if (full) begin
            result.verdict = V_FULL;
        end else begin
            slot_idx   = wr_idx;
            count_next = r_total + 1'b1;
        end
        slot_wide         = {{SLOT_BITS{1'b0}}, slot_idx};
        count_wide        = {{COUNT_BITS{1'b0}}, count_next};
        result.slot       = slot_wide[SLOT_BITS-1:0];
        result.kept_count = count_wide[COUNT_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign o_status.reject    = r_small || r_offs;
    assign o_status.scan_end  = (r_rd_idx == r_total);
    assign o_status.pipe_busy = r_v0 || r_v1 || r_v2;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

endmodule

// ===== rtl/rect_dedup_filter_top.sv =====
// Top level of the rectangle de-duplication filter.
// Depends on rdf_pkg, rdf_ctrl, rdf_dp (with rdf_ram) and the assertion macro header.
//
// Usage. Rectangles enter on the input channel (i_in_valid, o_in_stall,
// i_in_item) and each one yields exactly one item on the output channel
// (o_out_valid, i_out_stall, o_out_item) with its verdict, slot and the number
// of kept rectangles. The user must write the viewport registers through
// i_cfg_we, i_cfg_index, i_cfg_data only while idle; the block does not enforce it.
// Timing. An item is taken only while the sequencer is idle. A rejected
// rectangle skips the scan of the kept table; any other rectangle is compared
// with every kept rectangle, the kept table being read one slot per cycle
// through a single RAM read port feeding a four-stage compare pipeline. That
// read loop sets the throughput: the block takes a new item only after the
// result of the last one has been loaded into the output register.
// The output register separates the two sides, so the next item is accepted
// while a finished result still waits. If the receiver stalls, the result
// holds and the following item waits in its last step until the register
// frees. Reset empties the table, restores the default viewport and drops
// any pending result; the table itself needs no clearing pass.
`include "rect_dedup_filter_top_defines.svh"

module rect_dedup_filter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rdf_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [rdf_pkg::COORD_BITS-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  rdf_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output rdf_pkg::t_out_item                o_out_item
);

    import rdf_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    // The sequencer walks items through check, scan, drain, finish; rejects skip drain.
    rdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds the viewport, the kept table and the result register.
    rdf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    assign o_in_stall = !in_ready;

    // A new item must find the compare pipeline empty.
    `RDF_ASSERT_SAME(a_load_pipe_empty, i_clk, i_rst_n, cmd.load, !status.pipe_busy, "load busy")
    // The result is decided only after every compare has left the pipeline.
    `RDF_ASSERT_SAME(a_commit_drained, i_clk, i_rst_n, cmd.commit, !status.pipe_busy, "undrained")
    // No read is issued past the last kept slot.
    `RDF_ASSERT_SAME(a_issue_in_range, i_clk, i_rst_n, cmd.issue, !status.scan_end, "read range")
    // A decided result shows up on the output in the next cycle.
    `RDF_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, cmd.commit, o_out_valid, "no result")

endmodule

// ===== dv/rect_dedup_filter_top_tb.sv =====
// Self-checking testbench for rect_dedup_filter_top: directed and random rectangle streams,
// checked against a behavioral model of the greedy de-duplication table kept in the bench.
// Depends on rdf_pkg and the RTL of the filter; reads no files.
module rect_dedup_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rdf_pkg::*;

    // Cycles without any accepted item or taken result before the run is declared hung.
    localparam int STALL_LIMIT = 4000;
    // Length of the long receiver hold-off that backs the block up.
    localparam int HOLD_OFF_CYCLES = 400;
    // Cycles allowed after the last result for stray output items.
    localparam int TAIL_CYCLES = 80;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [COORD_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in_item in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out_item out_item;

    rect_dedup_filter_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Rectangles waiting to be offered, and verdicts waiting to be seen.
    t_in_item rects_to_send[$];
    t_out_item pending_verdicts[$];

    int rects_queued = 0;
    int rects_accepted = 0;
    int verdicts_checked = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    // Per-phase idling percentages, set by the sequencing block.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // Hold-off requests are counted so that only the stall process touches its counter.
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    logic in_took = 1'b0;

    // Model state: viewport shadow and the table of kept rectangles.
    longint view_edge[4] = '{0, 0, 1920, 1080};
    longint kept_l[MAX_KEPT];
    longint kept_t[MAX_KEPT];
    longint kept_r[MAX_KEPT];
    longint kept_b[MAX_KEPT];
    int kept_n = 0;

    // Region where fresh random rectangles are placed during a phase.
    int area_x = 0;
    int area_y = 0;
    int area_w = 1900;
    int area_h = 1060;

    // Two rectangles count as the same screen element when their truncated centers are
    // closer than ten, or when their overlap covers more than half of the smaller one.
    function automatic bit rects_similar(longint al, longint at, longint ar, longint ab,
                                         longint bl, longint bt, longint br, longint bb);
        longint dx, dy, il, it, ir, ib, inter, area_a, area_b, smaller;
        dx = (al + ar) / 2 - (bl + br) / 2;
        dy = (at + ab) / 2 - (bt + bb) / 2;
        if (dx * dx + dy * dy < NEAR_SQ)
            return 1'b1;
        il = (al > bl) ? al : bl;
        it = (at > bt) ? at : bt;
        ir = (ar < br) ? ar : br;
        ib = (ab < bb) ? ab : bb;
        if (ir <= il || ib <= it)
            return 1'b0;
        inter = (ir - il) * (ib - it);
        area_a = (ar - al) * (ab - at);
        area_b = (br - bl) * (bb - bt);
        smaller = (area_a < area_b) ? area_a : area_b;
        return smaller > 0 && inter * 2 > smaller;
    endfunction

    // Works out the verdict for one accepted rectangle and updates the kept table.
    function automatic t_out_item classify_rect(t_in_item item);
        t_out_item res;
        longint l, t, r, b;
        int hit;
        if (item.start_set)
            kept_n = 0;
        l = longint'($signed(item.edge_left));
        t = longint'($signed(item.edge_top));
        r = longint'($signed(item.edge_right));
        b = longint'($signed(item.edge_bottom));
        res.verdict = V_KEPT;
        res.slot = '0;
        hit = -1;
        if (r - l < MIN_SIDE || b - t < MIN_SIDE) begin
            res.verdict = V_SMALL;
        end else if (r < view_edge[CFG_VIEW_LEFT] || b < view_edge[CFG_VIEW_TOP] ||
                     l > view_edge[CFG_VIEW_RIGHT] || t > view_edge[CFG_VIEW_BOTTOM]) begin
            res.verdict = V_OFFSCREEN;
        end else begin
            for (int k = 0; k < kept_n && hit < 0; k++)
                if (rects_similar(l, t, r, b, kept_l[k], kept_t[k], kept_r[k], kept_b[k]))
                    hit = k;
            if (hit >= 0) begin
                res.verdict = V_DUP;
                res.slot = SLOT_BITS'(hit);
            end else if (kept_n >= MAX_KEPT) begin
                res.verdict = V_FULL;
            end else begin
                kept_l[kept_n] = l;
                kept_t[kept_n] = t;
                kept_r[kept_n] = r;
                kept_b[kept_n] = b;
                res.slot = SLOT_BITS'(kept_n);
                kept_n++;
            end
        end
        res.kept_count = COUNT_BITS'(kept_n);
        return res;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint v);
        longint hi;
        hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
        if (v > hi)
            v = hi;
        if (v < -hi - 1)
            v = -hi - 1;
        return COORD_BITS'(v);
    endfunction

    function automatic t_in_item pack_rect(logic st, longint l, longint t, longint r,
                                           longint b);
        t_in_item item;
        item.start_set = st;
        item.edge_left = clamp_coord(l);
        item.edge_top = clamp_coord(t);
        item.edge_right = clamp_coord(r);
        item.edge_bottom = clamp_coord(b);
        return item;
    endfunction

    function automatic longint pick(int span);
        return longint'($urandom_range(0, span));
    endfunction

    task automatic add_rect(t_in_item item);
        rects_to_send.insert(rects_to_send.size(), item);
        rects_queued++;
    endtask

    task automatic set_view(t_cfg_idx idx, int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= COORD_BITS'(value);
        view_edge[idx] = longint'($signed(COORD_BITS'(value)));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random rectangles, mostly grouped into scenes that open with a start item. Scenes
    // repeat earlier rectangles with small shifts so that the duplicate search gets real
    // work, and long scenes of small rectangles fill the table to its limit.
    task automatic queue_scenes(int count);
        int left_n, scene_len, kind, side_max, jit;
        bit long_scene;
        longint l, t, r, b, w, h;
        t_in_item item, base;
        t_in_item scene[$];
        left_n = count;
        while (left_n > 0) begin
            long_scene = ($urandom_range(0, 2) == 0);
            scene_len = long_scene ? $urandom_range(90, 140) : $urandom_range(1, 40);
            side_max = (long_scene || $urandom_range(0, 1)) ? 30 : 300;
            scene.delete();
            for (int k = 0; k < scene_len && left_n > 0; k++) begin
                kind = $urandom_range(0, 99);
                if (kind < 8) begin
                    // Noise: any bit pattern, start bit included.
                    item.start_set = ($urandom_range(0, 7) == 0);
                    item.edge_left = COORD_BITS'($urandom);
                    item.edge_top = COORD_BITS'($urandom);
                    item.edge_right = COORD_BITS'($urandom);
                    item.edge_bottom = COORD_BITS'($urandom);
                end else begin
                    l = area_x + pick(area_w);
                    t = area_y + pick(area_h);
                    if (kind < 16) begin
                        w = pick(19) - 10;
                        h = 10 + pick(side_max);
                        if ($urandom_range(0, 1)) begin
                            r = l + w;
                            b = t + h;
                        end else begin
                            r = l + h;
                            b = t + w;
                        end
                    end else if (kind < 24) begin
                        case ($urandom_range(0, 3))
                            0: begin
                                r = view_edge[CFG_VIEW_LEFT] - 1 - pick(300);
                                l = r - 10 - pick(200);
                                b = t + 10 + pick(100);
                            end
                            1: begin
                                b = view_edge[CFG_VIEW_TOP] - 1 - pick(300);
                                t = b - 10 - pick(200);
                                r = l + 10 + pick(100);
                            end
                            2: begin
                                l = view_edge[CFG_VIEW_RIGHT] + 1 + pick(300);
                                r = l + 10 + pick(200);
                                b = t + 10 + pick(100);
                            end
                            default: begin
                                t = view_edge[CFG_VIEW_BOTTOM] + 1 + pick(300);
                                b = t + 10 + pick(200);
                                r = l + 10 + pick(100);
                            end
                        endcase
                    end else if (kind < 45 && scene.size() > 0) begin
                        base = scene[$urandom_range(0, scene.size() - 1)];
                        jit = $urandom_range(0, 1) ? 12 : 60;
                        l = longint'($signed(base.edge_left)) + pick(2 * jit) - jit;
                        t = longint'($signed(base.edge_top)) + pick(2 * jit) - jit;
                        r = longint'($signed(base.edge_right)) + pick(2 * jit) - jit;
                        b = longint'($signed(base.edge_bottom)) + pick(2 * jit) - jit;
                    end else begin
                        r = l + 10 + pick(side_max);
                        b = t + 10 + pick(side_max);
                    end
                    item = pack_rect(k == 0, l, t, r, b);
                    scene.insert(scene.size(), item);
                end
                add_rect(item);
                left_n--;
            end
        end
    endtask

    // One phase: queue the random part, optionally ask for a long receiver hold-off, and
    // keep the sender quiet afterwards until every verdict has been checked.
    task automatic run_phase(int count, int idle_pct, int stall_pct, bit hold_off);
        @(posedge clk);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        queue_scenes(count);
        if (hold_off)
            hold_requests++;
        wait (rects_accepted == rects_queued && verdicts_checked == rects_accepted);
        @(negedge clk);
    endtask

    // Sender: presents the head of the queue, holds it until taken, idles at random.
    always @(negedge clk) begin
        if (in_took)
            void'(rects_to_send.pop_front());
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_took) begin
            // The offered item has not been taken yet, so it stays as it is.
        end else if (rects_to_send.size() > 0 &&
                     $urandom_range(0, 99) >= send_idle_pct) begin
            in_valid <= 1'b1;
            in_item <= rects_to_send[0];
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge clk) begin
        if (hold_requests != hold_served) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_served = hold_requests;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Both channels are sampled at the rising edge. An accepted rectangle is run through
    // the model at once, since the viewport only changes while nothing is in flight.
    always @(posedge clk) begin
        t_out_item want;
        in_took <= rst_n && in_valid && !in_stall;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                pending_verdicts.insert(pending_verdicts.size(), classify_rect(in_item));
                rects_accepted++;
            end
            if (out_valid && !out_stall) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: result with none expected, got verdict %0d slot %0d count %0d",
                             $time, out_item.verdict, out_item.slot, out_item.kept_count);
                    mismatch_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (out_item.verdict !== want.verdict) begin
                        $display("%0t: verdict mismatch, expected %0d, got %0d",
                                 $time, want.verdict, out_item.verdict);
                        mismatch_count++;
                    end
                    if (out_item.slot !== want.slot) begin
                        $display("%0t: slot mismatch, expected %0d, got %0d",
                                 $time, want.slot, out_item.slot);
                        mismatch_count++;
                    end
                    if (out_item.kept_count !== want.kept_count) begin
                        $display("%0t: kept count mismatch, expected %0d, got %0d",
                                 $time, want.kept_count, out_item.kept_count);
                        mismatch_count++;
                    end
                    verdicts_checked++;
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed scene on the reset viewport: size limits, the left and right viewport
        // edges just in and just out, the top and bottom edges just out, a near-center
        // duplicate, two rectangles exactly at the center distance and overlap limits,
        // containment, the full coordinate range, and a start carried by a rejected rectangle.
        @(posedge clk);
        add_rect(pack_rect(1'b1, 100, 100, 200, 200));
        add_rect(pack_rect(1'b0, 300, 300, 309, 400));
        add_rect(pack_rect(1'b0, 300, 300, 310, 400));
        add_rect(pack_rect(1'b0, 600, 600, 700, 609));
        add_rect(pack_rect(1'b0, 700, 700, 650, 800));
        add_rect(pack_rect(1'b0, -100, 100, -1, 200));
        add_rect(pack_rect(1'b0, -100, 100, 0, 200));
        add_rect(pack_rect(1'b0, 1921, 100, 2000, 200));
        add_rect(pack_rect(1'b0, 1920, 100, 2000, 200));
        add_rect(pack_rect(1'b0, 100, -50, 200, -1));
        add_rect(pack_rect(1'b0, 100, 1081, 200, 1200));
        add_rect(pack_rect(1'b0, 103, 104, 203, 204));
        add_rect(pack_rect(1'b0, 500, 500, 520, 520));
        add_rect(pack_rect(1'b0, 510, 500, 530, 520));
        add_rect(pack_rect(1'b0, 90, 90, 400, 400));
        add_rect(pack_rect(1'b0, -32768, -32768, 32767, 32767));
        add_rect(pack_rect(1'b1, 5, 5, 3, 3));
        add_rect(pack_rect(1'b0, 100, 100, 200, 200));
        add_rect(pack_rect(1'b0, 32767, 32767, -32768, -32768));
        add_rect(pack_rect(1'b0, -32768, 0, 32767, 10));
        run_phase(230, 0, 0, 1'b0);

        // Whole coordinate plane visible; the sender idles about half the time.
        set_view(CFG_VIEW_LEFT, -32768);
        set_view(CFG_VIEW_TOP, -32768);
        set_view(CFG_VIEW_RIGHT, 32767);
        set_view(CFG_VIEW_BOTTOM, 32767);
        area_x = -2000;
        area_y = -2000;
        area_w = 4000;
        area_h = 4000;
        run_phase(250, 52, 0, 1'b0);

        // Small viewport around the origin; the receiver stalls and holds off once.
        set_view(CFG_VIEW_LEFT, -500);
        set_view(CFG_VIEW_TOP, -300);
        set_view(CFG_VIEW_RIGHT, 800);
        set_view(CFG_VIEW_BOTTOM, 600);
        area_x = -600;
        area_y = -400;
        area_w = 1500;
        area_h = 1000;
        run_phase(250, 0, 52, 1'b1);

        // Inverted viewport: only a rectangle that spans the whole plane is on screen.
        set_view(CFG_VIEW_LEFT, 32767);
        set_view(CFG_VIEW_TOP, 32767);
        set_view(CFG_VIEW_RIGHT, -32768);
        set_view(CFG_VIEW_BOTTOM, -32768);
        area_x = -1000;
        area_y = -1000;
        area_w = 2000;
        area_h = 2000;
        @(posedge clk);
        add_rect(pack_rect(1'b1, -32768, -32768, 32767, 32767));
        add_rect(pack_rect(1'b0, -32768, -32768, 32767, 32766));
        run_phase(60, 25, 25, 1'b0);

        // Default viewport written back; both sides idle, with one more long hold-off.
        set_view(CFG_VIEW_LEFT, 0);
        set_view(CFG_VIEW_TOP, 0);
        set_view(CFG_VIEW_RIGHT, 1920);
        set_view(CFG_VIEW_BOTTOM, 1080);
        area_x = -50;
        area_y = -50;
        area_w = 1950;
        area_h = 1100;
        run_phase(240, 25, 25, 1'b1);

        // Give a stray extra result time to show up before judging.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rdf_pkg.sv
rtl/rdf_ram.sv
rtl/rdf_ctrl.sv
rtl/rdf_dp.sv
rtl/rect_dedup_filter_top.sv
dv/rect_dedup_filter_top_tb.sv
